// File: hw/rtl/kls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kls_pkg: shared definitions of the k-th largest selector
// Field widths, parameter defaults, result constants and sequencer states.
// ---------------------------------------------------------------------------
package kls_pkg;

   localparam int unsigned SCORE_W       = 32;
   localparam int unsigned INDEX_OUT_W   = 16;
   localparam int unsigned RANK_W        = 3;
   localparam int unsigned MAX_RANKS_DEF = 8;
   localparam int unsigned MAX_ITEMS_DEF = 65536;

   localparam logic signed [SCORE_W-1:0] NOT_FOUND_SCORE = -32'sd1;
   localparam logic [INDEX_OUT_W-1:0]    NOT_FOUND_INDEX = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_FINISH,
      ST_RESULT
   } state_type;

endpackage : kls_pkg
`default_nettype wire

// File: hw/rtl/kth_largest_selector.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kth_largest_selector: top-k buffer with rank selection
// Keeps the best MAX_RANKS scores of a set in descending order and, on the
// last request of the set, returns the score and arrival index at the
// configured rank.
// ---------------------------------------------------------------------------
// A request is accepted, then takes up to one compare-and-shift step per
//   kept entry before its score is placed or dropped; the last request of a
//   set adds a rank read and a result load. No new request is taken before
//   the last one is done: the single shared comparator steps through the
//   one-write, one-read buffer memory.
// Reset (synchronous, active high): sequencer idle, item count zero, rank 0,
//   no result pending; buffer contents are left as they are.
// ---------------------------------------------------------------------------
module kth_largest_selector #(
   parameter int unsigned MAX_RANKS = kls_pkg::MAX_RANKS_DEF,
   parameter int unsigned MAX_ITEMS = kls_pkg::MAX_ITEMS_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // request channel
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire signed [kls_pkg::SCORE_W-1:0]      req_score_value,
   input  wire                                    req_last_item,
   // response channel
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic                                   rsp_found,
   output logic signed [kls_pkg::SCORE_W-1:0]     rsp_chosen_score,
   output logic [kls_pkg::INDEX_OUT_W-1:0]        rsp_chosen_index,
   // configuration write channel
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire [kls_pkg::RANK_W-1:0]              csr_rank_wanted
);
   import kls_pkg::*;

   // buffer address, pointer (0..MAX_RANKS), index and count widths
   localparam int unsigned AW = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
   localparam int unsigned PW = $clog2(MAX_RANKS + 1);
   localparam int unsigned IW = $clog2(MAX_ITEMS);
   localparam int unsigned SW = $clog2(MAX_ITEMS + 1);

   // -------------------------------------------------------------------------
   // Buffer memory: descending scores with their arrival indices
   // -------------------------------------------------------------------------
   logic signed [SCORE_W-1:0] mem_score [MAX_RANKS];
   logic [IW-1:0]             mem_index [MAX_RANKS];

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic signed [SCORE_W-1:0] wr_score;
   logic [IW-1:0]             wr_index;
   logic [AW-1:0]             rd_addr;
   logic signed [SCORE_W-1:0] rd_score_ff;
   logic [IW-1:0]             rd_index_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_score[wr_addr] <= wr_score;
         mem_index[wr_addr] <= wr_index;
      end
      rd_score_ff <= mem_score[rd_addr];
      rd_index_ff <= mem_index[rd_addr];
   end

   // -------------------------------------------------------------------------
   // Sequencer and working registers
   // -------------------------------------------------------------------------
   state_type                 state_ff, state_in;
   logic [PW-1:0]             ptr_ff, ptr_in;        // slot being decided
   logic signed [SCORE_W-1:0] score_ff, score_in;    // incoming score
   logic [IW-1:0]             idx_ff, idx_in;        // its arrival index
   logic                      last_ff, last_in;
   logic [SW-1:0]             items_seen_ff, items_seen_in;
   logic [RANK_W-1:0]         rank_ff, rank_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic signed [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic [INDEX_OUT_W-1:0]    rsp_index_ff, rsp_index_in;

   logic                      req_take;
   logic [PW-1:0]             kept;
   logic                      kept_full;
   logic                      keep_old;   // kept entry stays ahead of new score
   logic                      slot_real;  // pointer addresses a real slot
   logic                      found;
   logic [AW-1:0]             rank_addr;
   logic                      out_free;
   logic                      load_rsp;
   state_type                 after_insert;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign kept_full = (32'(items_seen_ff) >= 32'(MAX_RANKS));
   assign kept      = kept_full ? PW'(MAX_RANKS) : PW'(items_seen_ff);
   assign keep_old  = (rd_score_ff >= score_ff);
   assign slot_real = (32'(ptr_ff) < 32'(MAX_RANKS));
   assign found     = (32'(rank_ff) < 32'(items_seen_ff))
                   && (32'(rank_ff) < 32'(MAX_RANKS));
   assign rank_addr = found ? AW'(rank_ff) : '0;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign after_insert = last_ff ? ST_FINISH : ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         items_seen_ff <= '0;
         rank_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         items_seen_ff <= items_seen_in;
         rank_ff       <= rank_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      score_ff     <= score_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      rsp_found_ff <= rsp_found_in;
      rsp_score_ff <= rsp_score_in;
      rsp_index_ff <= rsp_index_in;
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      score_in      = score_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      items_seen_in = items_seen_ff;
      rank_in       = (csr_valid && csr_ready) ? csr_rank_wanted : rank_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      wr_en         = 1'b0;
      wr_addr       = AW'(ptr_ff);
      wr_score      = score_ff;
      wr_index      = idx_ff;
      rd_addr       = '0;
      load_rsp      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // latch the request, number it and count it
               score_in = req_score_value;
               last_in  = req_last_item;
               idx_in   = (32'(items_seen_ff) < 32'(MAX_ITEMS - 1))
                        ? IW'(items_seen_ff) : IW'(MAX_ITEMS - 1);
               if (32'(items_seen_ff) < 32'(MAX_ITEMS)) begin
                  items_seen_in = items_seen_ff + SW'(1);
               end
               ptr_in = kept;
               if (kept == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  // fetch the last kept entry for the first compare
                  rd_addr  = AW'(kept - PW'(1));
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // rd_*_ff holds the entry just ahead of slot ptr_ff
            if (keep_old) begin
               // new score settles at ptr_ff, or drops if beyond the buffer
               wr_en    = slot_real;
               state_in = after_insert;
            end else begin
               // shift the smaller entry back one slot, advance forward
               wr_en    = slot_real;
               wr_score = rd_score_ff;
               wr_index = rd_index_ff;
               ptr_in   = ptr_ff - PW'(1);
               if (ptr_ff == PW'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_addr = AW'(ptr_ff - PW'(2));
               end
            end
         end

         ST_PLACE: begin
            // new score goes to the head slot
            wr_en    = 1'b1;
            state_in = after_insert;
         end

         ST_FINISH: begin
            rd_addr  = rank_addr;
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            // hold the read address so the read data stays put while waiting
            rd_addr = rank_addr;
            if (out_free) begin
               load_rsp      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found;
               rsp_score_in  = found ? rd_score_ff : NOT_FOUND_SCORE;
               rsp_index_in  = found ? INDEX_OUT_W'(rd_index_ff) : NOT_FOUND_INDEX;
               items_seen_in = '0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_chosen_score = rsp_score_ff;
   assign rsp_chosen_index = rsp_index_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_scan_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (ptr_ff != '0) && (32'(ptr_ff) <= 32'(MAX_RANKS)))
      else $error("scan pointer out of range");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      32'(items_seen_ff) <= 32'(MAX_ITEMS))
      else $error("item count beyond saturation");

   a_not_found_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff)
         |-> (rsp_score_ff == NOT_FOUND_SCORE) && (rsp_index_ff == NOT_FOUND_INDEX))
      else $error("not-found response carries a payload");

   a_set_clears: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (items_seen_ff == '0) && (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("set did not clear after response");

   a_no_busy_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT) && !out_free |=> (state_ff == ST_RESULT))
      else $error("result lost while response was stalled");

endmodule : kth_largest_selector
`default_nettype wire

// File: tb/tb_kth_largest_selector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_kth_largest_selector: self-checking bench of the k-th largest selector
// Streams sets of signed scores into the block, mirrors its top-k buffer in a
// local predictor and checks every returned pick field by field, under random
// idling on both channels and across every rank setting.
// ---------------------------------------------------------------------------
module tb_kth_largest_selector;
   import kls_pkg::*;

   localparam int unsigned RANKS         = MAX_RANKS_DEF;
   localparam int unsigned ITEMS         = MAX_ITEMS_DEF;
   // Quiet time before a rank write: worst request occupancy plus margin.
   localparam int unsigned SETTLE_CYCLES = RANKS + 8;
   localparam int unsigned IDLE_PCT      = 33;
   localparam int unsigned RANDOM_ITEMS  = 1000;

   typedef struct packed {
      logic                       found;
      logic signed [SCORE_W-1:0]  score;
      logic [INDEX_OUT_W-1:0]     index;
   } pick_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SCORE_W-1:0]     req_score_value = '0;
   logic                          req_last_item = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_found;
   logic signed [SCORE_W-1:0]     rsp_chosen_score;
   logic [INDEX_OUT_W-1:0]        rsp_chosen_index;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [RANK_W-1:0]             csr_rank_wanted = '0;

   // Predictor state: descending top-k buffer, item count and selected rank.
   logic signed [SCORE_W-1:0]     kept_scores [RANKS];
   int unsigned                   kept_indices [RANKS];
   int unsigned                   set_count = 0;
   logic [RANK_W-1:0]             rank_sel = '0;

   pick_type                      pending_picks [$];
   int unsigned                   mismatch_count = 0;
   // Suppress idling on both channels while set.
   bit                            quiet = 1'b0;

   kth_largest_selector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_score_value  (req_score_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_chosen_score (rsp_chosen_score),
      .rsp_chosen_index (rsp_chosen_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_rank_wanted  (csr_rank_wanted)
   );

   always #4 clock = ~clock;

   // Bound the run well beyond the slowest legal schedule.
   initial begin
      #40_000_000;
      $display("kth_largest_selector verification failed");
      $finish;
   end

   // Stall the result side at random, except during quiet stretches.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Merge one accepted score into the predicted buffer; on the last request
   // of a set, queue the expected pick and clear the set.
   task automatic rank_buffer_insert(input logic signed [SCORE_W-1:0] score,
                                     input logic last);
      int unsigned arrival;
      int unsigned kept;
      int unsigned pos;
      int unsigned i;
      pick_type    pick;
      arrival = (set_count < ITEMS - 1) ? set_count : ITEMS - 1;
      kept    = (set_count < RANKS) ? set_count : RANKS;
      pos     = 0;
      // Insert behind every kept score that is not smaller: ties keep order.
      while (pos < kept && kept_scores[pos] >= score) pos++;
      if (pos < RANKS) begin
         i = (kept < RANKS) ? kept : RANKS - 1;
         while (i > pos) begin
            kept_scores[i]  = kept_scores[i-1];
            kept_indices[i] = kept_indices[i-1];
            i--;
         end
         kept_scores[pos]  = score;
         kept_indices[pos] = arrival;
      end
      if (set_count < ITEMS) set_count++;
      if (last) begin
         if (rank_sel < set_count && rank_sel < RANKS) begin
            pick.found = 1'b1;
            pick.score = kept_scores[rank_sel];
            pick.index = kept_indices[rank_sel][INDEX_OUT_W-1:0];
         end else begin
            pick.found = 1'b0;
            pick.score = NOT_FOUND_SCORE;
            pick.index = NOT_FOUND_INDEX;
         end
         pending_picks = {pending_picks, pick};
         set_count = 0;
      end
   endtask

   // Check each accepted result against the oldest queued pick.
   always @(posedge clock) begin : check_picks
      pick_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_picks.size() == 0) begin
            mismatch_count++;
            $display("%0t: result expected none actual found=%0b score=%0d index=%0d",
                     $time, rsp_found, rsp_chosen_score, rsp_chosen_index);
         end else begin
            want = pending_picks.pop_front();
            if (rsp_found !== want.found) begin
               mismatch_count++;
               $display("%0t: found expected %0b actual %0b",
                        $time, want.found, rsp_found);
            end
            if (rsp_chosen_score !== want.score) begin
               mismatch_count++;
               $display("%0t: chosen_score expected %0d actual %0d",
                        $time, want.score, rsp_chosen_score);
            end
            if (rsp_chosen_index !== want.index) begin
               mismatch_count++;
               $display("%0t: chosen_index expected %0d actual %0d",
                        $time, want.index, rsp_chosen_index);
            end
         end
      end
   end

   // Present one request, possibly after a random gap, and hold it until the
   // block takes it. Valid stays high on return so back-to-back requests
   // need no extra edge.
   task automatic send_score(input logic signed [SCORE_W-1:0] score,
                             input logic last);
      if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_score_value <= score;
      req_last_item   <= last;
      do @(posedge clock); while (req_stall);
      rank_buffer_insert(score, last);
   endtask

   // Drop valid, wait for every queued pick, then let the block go quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_rank(input logic [RANK_W-1:0] rank);
      settle_block();
      csr_valid       <= 1'b1;
      csr_rank_wanted <= rank;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rank_sel = rank;
   endtask

   // Score mix: full range, a narrow band for ties, extremes, moderate values.
   function automatic logic signed [SCORE_W-1:0] draw_score();
      int unsigned mode;
      mode = $urandom_range(0, 99);
      if (mode < 25) return $urandom;
      if (mode < 50) return $signed($urandom_range(0, 8)) - 4;
      if (mode < 65) begin
         case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return 32'sd1;
         endcase
      end
      return $signed($urandom_range(0, 2000)) - 1000;
   endfunction

   // Reset-default rank with the full-range extremes of the score.
   task automatic test_extremes();
      send_score(32'sh8000_0000, 1'b0);
      send_score(32'sh7FFF_FFFF, 1'b0);
      send_score(-32'sd1, 1'b0);
      send_score(32'sd0, 1'b1);
   endtask

   // One-item sets: found at rank 0, not found when rank reaches the count.
   task automatic test_single_item();
      send_score(32'sh8000_0000, 1'b1);
      set_rank(RANK_W'(1));
      send_score(32'sd5, 1'b1);
   endtask

   // Equal scores keep arrival order and never displace a kept entry.
   task automatic test_ties();
      set_rank(RANK_W'(2));
      send_score(32'sd5, 1'b0);
      send_score(32'sd5, 1'b0);
      send_score(32'sd9, 1'b0);
      send_score(32'sd5, 1'b1);
   endtask

   // Fill the buffer, then evict its smallest entry; read the deepest rank.
   task automatic test_full_buffer();
      int unsigned k;
      set_rank(RANK_W'(RANKS - 1));
      for (k = 0; k < RANKS; k++) send_score(90 - 10 * k, 1'b0);
      send_score(32'sd85, 1'b1);
   endtask

   // A rank written in the middle of a set applies to that set's pick.
   task automatic test_rank_change_mid_set();
      set_rank(RANK_W'(0));
      send_score(32'sd3, 1'b0);
      send_score(32'sd7, 1'b0);
      set_rank(RANK_W'(1));
      send_score(32'sd5, 1'b1);
   endtask

   task automatic test_random_sets();
      int unsigned sent;
      int unsigned len;
      int unsigned mid;
      int unsigned k;
      int unsigned pick_len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // Hold a long stretch with no idling on either side.
         quiet = (sent >= 400 && sent < 560);
         if ($urandom_range(0, 7) == 0)
            set_rank(RANK_W'($urandom_range(0, RANKS - 1)));
         else if ($urandom_range(0, 15) == 0)
            settle_block();
         pick_len = $urandom_range(0, 99);
         if (pick_len < 80)
            len = $urandom_range(1, 10);
         else if (pick_len < 95)
            len = $urandom_range(11, 24);
         else
            len = $urandom_range(25, 60);
         mid = (len > 2 && $urandom_range(0, 11) == 0) ? $urandom_range(1, len - 1) : 0;
         for (k = 0; k < len; k++) begin
            if (mid != 0 && k == mid) set_rank(RANK_W'($urandom_range(0, RANKS - 1)));
            send_score(draw_score(), k == len - 1);
         end
         sent += len;
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_single_item();
      test_ties();
      test_full_buffer();
      test_rank_change_mid_set();
      test_random_sets();
      set_rank(RANK_W'(0));
      test_extremes();
      settle_block();
      if (mismatch_count == 0 && pending_picks.size() == 0) begin
         $display("kth_largest_selector verification clean");
      end else begin
         $display("kth_largest_selector verification failed");
      end
      $finish;
   end

endmodule
